@@ hdl/ccs_pkg.sv @@
// shared types, constants and widths of the cubic curve subdivider
package ccs_pkg;

  // fixed field widths
  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned CfgWidth    = 64;
  localparam int unsigned CfgIdxWidth = 2;

  // shape of the computation
  localparam int unsigned Axes      = 3;
  localparam int unsigned Taps      = 4;
  localparam int unsigned Rows      = 4;
  localparam int unsigned Samples   = 4;
  localparam int unsigned HistDepth = 3;
  localparam int unsigned HeldWidth = 2;

  localparam int unsigned RowIdxWidth    = $clog2(Rows);
  localparam int unsigned SampleIdxWidth = $clog2(Samples);

  // samples are scaled by 4^3 so that t = k/4 stays integral
  localparam int unsigned SampleScaleLog2 = 6;

  // coefficient: weight x coord summed over four taps
  localparam int unsigned ProdWidth = CoordWidth + WeightWidth;
  localparam int unsigned CoefWidth = ProdWidth + 2;
  // sample sum: four terms each up to 64 x coefficient
  localparam int unsigned SumWidth  = CoefWidth + SampleScaleLog2 + 2;

  localparam int unsigned CoefFracBitsDefault = 12;
  localparam int unsigned QueueDepth          = 2;

  typedef logic signed [CoordWidth-1:0]  coord_t;
  typedef logic signed [WeightWidth-1:0] weight_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic signed [SumWidth-1:0]    sum_t;

  typedef logic [CfgWidth-1:0]    cfg_data_t;
  typedef logic [CfgIdxWidth-1:0] cfg_idx_t;
  typedef logic [RowIdxWidth-1:0] row_idx_t;
  typedef logic [SampleIdxWidth-1:0] sample_idx_t;
  typedef logic [HeldWidth-1:0]   held_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } point_t;

  typedef struct packed {
    coord_t sample_x;
    coord_t sample_y;
    coord_t sample_z;
    logic   last_sample;
  } sample_t;

  // index 0 is the oldest point of the window
  typedef point_t [Taps-1:0] window_t;

  // row 0 cubic, row 1 quadratic, row 2 linear, row 3 constant; axis 0 x, 1 y, 2 z
  typedef coef_t     [Axes-1:0] coef_row_t;
  typedef coef_row_t [Rows-1:0] coef_set_t;

endpackage

@@ hdl/cubic_curve_subdivider.sv @@
// top level of the cubic curve subdivider
//
// input channel: one 3-D control point per beat (in_valid_i / in_ready_o)
// output channel: curve samples at t = 1/4, 1/2, 3/4, 1 (out_valid_o /
//   out_ready_i), the fourth beat carries last_sample
// config: basis rows t3, t2, t1, t0 at indices 0..3 through cfg_we_i,
//   four signed Q4.12 weights per row, written while the block is idle
// the first three points only fill the history and give no output; every
//   later point completes a window of four and yields four samples
// the completing point passes through the window queue, the coefficient unit
//   and the evaluator's coefficient and output registers before its first sample
//   shows on out_valid_o, then one sample per cycle while the receiver does not
//   stall; the coefficient unit takes one basis row per cycle and the output carries 4 beats per point
// a two-entry window queue lets the front keep taking points while the back
//   works, so short bursts are accepted at one point per cycle
// when the receiver stalls the output register holds its beat, the evaluator
//   and coefficient unit stop, the queue fills and then in_ready_o drops
// reset clears the history count, queue, sequencing and basis rows (all zero)
module cubic_curve_subdivider #(
  parameter int unsigned COEF_FRAC_BITS = ccs_pkg::CoefFracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // point input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccs_pkg::point_t     in_data_i,
  // sample output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccs_pkg::sample_t    out_data_o,
  // basis configuration
  input  logic                cfg_we_i,
  input  ccs_pkg::cfg_idx_t   cfg_idx_i,
  input  ccs_pkg::cfg_data_t  cfg_data_i
);

  // front to queue
  logic               push_valid, push_ready;
  ccs_pkg::window_t   push_data;
  // queue to coefficient unit
  logic               win_valid, win_ready;
  ccs_pkg::window_t   win_data;
  // coefficient unit to evaluator
  logic               coef_valid, coef_ready;
  ccs_pkg::coef_set_t coef_data;

  // history and window issue
  ccs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples the front from the back
  ccs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (win_valid),
    .pop_ready_i  (win_ready),
    .pop_data_o   (win_data)
  );

  // basis matrix times window, one row per cycle, last row held until taken
  ccs_coef u_coef (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .win_valid_i  (win_valid),
    .win_ready_o  (win_ready),
    .win_i        (win_data),
    .coef_valid_o (coef_valid),
    .coef_ready_i (coef_ready),
    .coef_o       (coef_data)
  );

  // exact sample evaluation, truncation and saturation
  ccs_eval #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_valid_i (coef_valid),
    .coef_ready_o (coef_ready),
    .coef_i       (coef_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ hdl/ccs_front.sv @@
// front end: point history, fill tracking and window issue into the queue
module ccs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ccs_pkg::point_t   in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ccs_pkg::window_t  push_data_o
);

  ccs_pkg::held_t  held_q, held_d;
  ccs_pkg::point_t hist_q [ccs_pkg::HistDepth];
  logic            full;
  logic            accept;

  assign full         = (held_q == ccs_pkg::HeldWidth'(ccs_pkg::HistDepth));
  assign in_ready_o   = !full || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = in_valid_i && full;

  always_comb begin
    for (int j = 0; j < ccs_pkg::HistDepth; j++) begin
      push_data_o[j] = hist_q[j];
    end
    push_data_o[ccs_pkg::Taps-1] = in_data_i;
  end

  always_comb begin
    held_d = held_q;
    if (accept && !full) begin
      held_d = held_q + ccs_pkg::HeldWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  // history: append while filling, slide once full
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!full) begin
        hist_q[held_q] <= in_data_i;
      end else begin
        for (int j = 0; j < ccs_pkg::HistDepth - 1; j++) begin
          hist_q[j] <= hist_q[j+1];
        end
        hist_q[ccs_pkg::HistDepth-1] <= in_data_i;
      end
    end
  end

endmodule

@@ hdl/ccs_fifo.sv @@
// short window queue between front end and back end
module ccs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  ccs_pkg::window_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output ccs_pkg::window_t  pop_data_o
);

  localparam int unsigned PtrWidth = $clog2(ccs_pkg::QueueDepth);
  localparam int unsigned CntWidth = $clog2(ccs_pkg::QueueDepth + 1);

  ccs_pkg::window_t      mem_q [ccs_pkg::QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != CntWidth'(ccs_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(ccs_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(ccs_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + PtrWidth'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/ccs_coef.sv @@
// coefficient unit: basis registers and one basis row per cycle for all axes
module ccs_coef (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ccs_pkg::cfg_idx_t   cfg_idx_i,
  input  ccs_pkg::cfg_data_t  cfg_data_i,
  input  logic                win_valid_i,
  output logic                win_ready_o,
  input  ccs_pkg::window_t    win_i,
  output logic                coef_valid_o,
  input  logic                coef_ready_i,
  output ccs_pkg::coef_set_t  coef_o
);

  localparam ccs_pkg::row_idx_t LastRow = ccs_pkg::RowIdxWidth'(ccs_pkg::Rows - 1);

  ccs_pkg::cfg_data_t  basis_q [ccs_pkg::Rows];
  ccs_pkg::row_idx_t   row_q, row_d;
  ccs_pkg::coef_row_t  rows_q [ccs_pkg::Rows-1];
  ccs_pkg::coef_row_t  row_sum;
  ccs_pkg::cfg_data_t  row_w;
  logic                last_row;

  // one row of weights against the four window points, per axis
  always_comb begin
    ccs_pkg::coord_t  pts [ccs_pkg::Taps][ccs_pkg::Axes];
    ccs_pkg::weight_t w;
    ccs_pkg::prod_t   p;
    row_w = basis_q[row_q];
    for (int j = 0; j < ccs_pkg::Taps; j++) begin
      pts[j][0] = win_i[j].point_x;
      pts[j][1] = win_i[j].point_y;
      pts[j][2] = win_i[j].point_z;
    end
    for (int ax = 0; ax < ccs_pkg::Axes; ax++) begin
      row_sum[ax] = '0;
      for (int j = 0; j < ccs_pkg::Taps; j++) begin
        w = row_w[j*ccs_pkg::WeightWidth +: ccs_pkg::WeightWidth];
        p = w * pts[j][ax];
        row_sum[ax] = row_sum[ax] + ccs_pkg::coef_t'(p);
      end
    end
  end

  assign last_row     = (row_q == LastRow);
  assign coef_valid_o = win_valid_i && last_row;
  assign win_ready_o  = coef_valid_o && coef_ready_i;

  always_comb begin
    for (int r = 0; r < ccs_pkg::Rows - 1; r++) begin
      coef_o[r] = rows_q[r];
    end
    coef_o[ccs_pkg::Rows-1] = row_sum;
  end

  always_comb begin
    row_d = row_q;
    if (win_valid_i && !last_row) begin
      row_d = row_q + ccs_pkg::RowIdxWidth'(1);
    end else if (win_ready_o) begin
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      for (int r = 0; r < ccs_pkg::Rows; r++) begin
        basis_q[r] <= '0;
      end
    end else begin
      row_q <= row_d;
      if (cfg_we_i) begin
        basis_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_valid_i && !last_row) begin
      rows_q[row_q] <= row_sum;
    end
  end

endmodule

@@ hdl/ccs_eval.sv @@
// sample evaluator: four samples per coefficient set into the output register
module ccs_eval #(
  parameter int unsigned COEF_FRAC_BITS = ccs_pkg::CoefFracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                coef_valid_i,
  output logic                coef_ready_o,
  input  ccs_pkg::coef_set_t  coef_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccs_pkg::sample_t    out_data_o
);

  localparam int unsigned Shift = ccs_pkg::SampleScaleLog2 + COEF_FRAC_BITS;
  localparam ccs_pkg::sum_t RoundBias = ccs_pkg::sum_t'(2**Shift - 1);
  localparam ccs_pkg::sum_t SatHi = ccs_pkg::sum_t'(2**(ccs_pkg::CoordWidth-1) - 1);
  localparam ccs_pkg::sum_t SatLo = ccs_pkg::sum_t'(-(2**(ccs_pkg::CoordWidth-1)));
  localparam ccs_pkg::sample_idx_t LastK =
    ccs_pkg::SampleIdxWidth'(ccs_pkg::Samples - 1);

  // 64 * p(k/4) = a*k^3 + 4*b*k^2 + 16*c*k + 64*d, k = idx + 1
  function automatic ccs_pkg::sum_t sample_sum(ccs_pkg::coef_t a, ccs_pkg::coef_t b,
                                               ccs_pkg::coef_t c, ccs_pkg::coef_t d,
                                               ccs_pkg::sample_idx_t k);
    ccs_pkg::sum_t sa, sb, sc, sd, s;
    sa = ccs_pkg::sum_t'(a);
    sb = ccs_pkg::sum_t'(b);
    sc = ccs_pkg::sum_t'(c);
    sd = ccs_pkg::sum_t'(d);
    case (k)
      2'd0:    s = sa + (sb <<< 2) + (sc <<< 4) + (sd <<< 6);
      2'd1:    s = (sa <<< 3) + (sb <<< 4) + (sc <<< 5) + (sd <<< 6);
      2'd2:    s = sa * 27 + sb * 36 + sc * 48 + (sd <<< 6);
      default: s = (sa <<< 6) + (sb <<< 6) + (sc <<< 6) + (sd <<< 6);
    endcase
    return s;
  endfunction

  // divide by 2^Shift toward zero, then clamp to the coordinate range
  function automatic ccs_pkg::coord_t scale_sat(ccs_pkg::sum_t s);
    ccs_pkg::sum_t biased, q;
    ccs_pkg::coord_t r;
    biased = s[ccs_pkg::SumWidth-1] ? s + RoundBias : s;
    q      = biased >>> Shift;
    if (q > SatHi) begin
      r = SatHi[ccs_pkg::CoordWidth-1:0];
    end else if (q < SatLo) begin
      r = SatLo[ccs_pkg::CoordWidth-1:0];
    end else begin
      r = q[ccs_pkg::CoordWidth-1:0];
    end
    return r;
  endfunction

  ccs_pkg::coef_set_t   coef_q;
  logic                 ev_valid_q, ev_valid_d;
  ccs_pkg::sample_idx_t k_q, k_d;
  logic                 out_valid_q, out_valid_d;
  ccs_pkg::sample_t     out_q, out_d;
  logic                 issue, last_issue, load;

  assign issue        = ev_valid_q && (!out_valid_q || out_ready_i);
  assign last_issue   = issue && (k_q == LastK);
  assign coef_ready_o = !ev_valid_q || last_issue;
  assign load         = coef_valid_i && coef_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  always_comb begin
    out_d.sample_x    = scale_sat(sample_sum(coef_q[0][0], coef_q[1][0],
                                             coef_q[2][0], coef_q[3][0], k_q));
    out_d.sample_y    = scale_sat(sample_sum(coef_q[0][1], coef_q[1][1],
                                             coef_q[2][1], coef_q[3][1], k_q));
    out_d.sample_z    = scale_sat(sample_sum(coef_q[0][2], coef_q[1][2],
                                             coef_q[2][2], coef_q[3][2], k_q));
    out_d.last_sample = (k_q == LastK);
  end

  always_comb begin
    ev_valid_d  = ev_valid_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      ev_valid_d = 1'b1;
      k_d        = '0;
    end else if (last_issue) begin
      ev_valid_d = 1'b0;
    end else if (issue) begin
      k_d = k_q + ccs_pkg::SampleIdxWidth'(1);
    end
    if (issue) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q  <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ev_valid_q  <= ev_valid_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q <= coef_i;
    end
    if (issue) begin
      out_q <= out_d;
    end
  end

endmodule

@@ hdl/ccs_checker.sv @@
// port level checks for the cubic curve subdivider, bound to the top level
module ccs_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  ccs_pkg::sample_t    out_data_o
);

  localparam logic [2:0] WindowFull = 3'(ccs_pkg::Taps);
  localparam ccs_pkg::sample_idx_t LastK =
    ccs_pkg::SampleIdxWidth'(ccs_pkg::Samples - 1);

  logic [2:0]           seen_q, seen_d;
  ccs_pkg::sample_idx_t beat_q, beat_d;

  // points accepted, held at four once a window can form
  always_comb begin
    seen_d = seen_q;
    if (in_valid_i && in_ready_o && (seen_q != WindowFull)) begin
      seen_d = seen_q + 3'(1);
    end
    beat_d = beat_q;
    if (out_valid_o && out_ready_i) begin
      beat_d = beat_q + ccs_pkg::SampleIdxWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      beat_q <= '0;
    end else begin
      seen_q <= seen_d;
      beat_q <= beat_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q == WindowFull)
    else $error("sample before four points were accepted");

  a_last_every_fourth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> out_data_o.last_sample == (beat_q == LastK))
    else $error("last_sample not on every fourth beat");

endmodule

bind cubic_curve_subdivider ccs_checker u_checker (.*);

@@ tb/testbench.sv @@
// self-checking testbench for the cubic curve subdivider: random beats, basis sweeps, stalls
module testbench;
  import ccs_pkg::*;

  // basis register map, index i is row i of the configuration list
  typedef enum logic [1:0] {
    RegRowT3 = 2'd0,
    RegRowT2 = 2'd1,
    RegRowT1 = 2'd2,
    RegRowT0 = 2'd3
  } basis_reg_e;

  localparam int unsigned FracBits    = CoefFracBitsDefault;
  localparam longint      SampleDenom = longint'(1) << (SampleScaleLog2 + FracBits);
  localparam longint      CoordMax    = (longint'(1) << (CoordWidth - 1)) - 1;
  localparam longint      CoordMin    = -CoordMax - 1;
  localparam int          SettleCycles = 16;
  localparam int          HoldOffCycles = 300;   // long receiver stall, fills the window queue
  localparam longint      CycleLimit  = 300000;
  localparam int          PhaseItems  = 50;

  // extreme rows: every weight at the top or bottom of the Q4.12 range
  localparam cfg_data_t MaxRow = {4{16'h7fff}};
  localparam cfg_data_t MinRow = {4{16'h8000}};

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  point_t    in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  sample_t   out_data_o;
  logic      cfg_we_i = 1'b0;
  cfg_idx_t  cfg_idx_i = '0;
  cfg_data_t cfg_data_i = '0;

  cubic_curve_subdivider dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // points still to be offered, and curve samples still owed by the block
  point_t    pending_points [$];
  sample_t   expected_samples [$];

  // own copy of the block's state: basis rows and the sliding point history
  cfg_data_t   basis_rows [4];
  point_t      point_hist [3];
  int unsigned held_count = 0;

  int  mismatch_count = 0;
  bit  in_beat = 1'b0;     // an input beat went across at the last rising edge
  bit  quiet = 1'b0;       // no idling on either side while set
  bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  longint cycle_count = 0;

  // idle length: mostly short, now and then long
  function automatic int next_gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // weights for P0..P3, P0 in the low 16 bits
  function automatic cfg_data_t pack_row(int w0, int w1, int w2, int w3);
    return {weight_t'(w3), weight_t'(w2), weight_t'(w1), weight_t'(w0)};
  endfunction

  // random weights within about +-1.0, where the samples mostly stay in range
  function automatic cfg_data_t small_row();
    return pack_row(int'($urandom_range(0, 8192)) - 4096,
                    int'($urandom_range(0, 8192)) - 4096,
                    int'($urandom_range(0, 8192)) - 4096,
                    int'($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic coord_t random_coord(int unsigned kind);
    case (kind)
      0: begin
        case ($urandom_range(0, 4))
          0: return coord_t'(CoordMax);
          1: return coord_t'(CoordMin);
          2: return '0;
          3: return coord_t'(1);
          default: return coord_t'(-1);
        endcase
      end
      1: return coord_t'($urandom);
      default: return coord_t'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  // one kind per point so whole points land near the extremes, wide or small
  function automatic point_t random_point();
    point_t      p;
    int unsigned r;
    int unsigned kind;
    r = $urandom_range(0, 99);
    kind = (r < 15) ? 0 : (r < 60) ? 1 : 2;
    p.point_x = random_coord(kind);
    p.point_y = random_coord(kind);
    p.point_z = random_coord(kind);
    return p;
  endfunction

  function automatic longint axis_of(point_t p, int ax);
    case (ax)
      0: return longint'(p.point_x);
      1: return longint'(p.point_y);
      default: return longint'(p.point_z);
    endcase
  endfunction

  // works out the samples one accepted point causes and slides the history
  task automatic predict_samples(input point_t p);
    longint  win [4][3];
    longint  coef [4][3];
    longint  val [3];
    longint  acc;
    longint  s;
    longint  k;
    weight_t w;
    sample_t smp;
    // filling: the first three points are only stored
    if (held_count < 3) begin
      point_hist[held_count] = p;
      held_count++;
      return;
    end
    for (int j = 0; j < 3; j++)
      for (int ax = 0; ax < 3; ax++)
        win[j][ax] = axis_of(point_hist[j], ax);
    for (int ax = 0; ax < 3; ax++)
      win[3][ax] = axis_of(p, ax);
    // coefficients in units of 2^-12: basis row times the window, per axis
    for (int r = 0; r < 4; r++)
      for (int ax = 0; ax < 3; ax++) begin
        acc = 0;
        for (int j = 0; j < 4; j++) begin
          w = basis_rows[r][16*j +: 16];
          acc += longint'(w) * win[j][ax];
        end
        coef[r][ax] = acc;
      end
    // t = k/4, scaled by 64 so the sum stays integral; divide truncates toward zero
    for (int i = 1; i <= 4; i++) begin
      k = longint'(i);
      for (int ax = 0; ax < 3; ax++) begin
        s = coef[0][ax] * k * k * k + 4 * coef[1][ax] * k * k
          + 16 * coef[2][ax] * k + 64 * coef[3][ax];
        val[ax] = s / SampleDenom;
        if (val[ax] > CoordMax) val[ax] = CoordMax;
        else if (val[ax] < CoordMin) val[ax] = CoordMin;
      end
      smp.sample_x    = coord_t'(val[0]);
      smp.sample_y    = coord_t'(val[1]);
      smp.sample_z    = coord_t'(val[2]);
      smp.last_sample = (i == 4);
      expected_samples.push_back(smp);
    end
    point_hist[0] = point_hist[1];
    point_hist[1] = point_hist[2];
    point_hist[2] = p;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // monitor: output beats checked against the oldest owed sample, input beats
  // fed to the predictor; outputs first, a point can never give a sample in
  // the cycle it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sample_t got;
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample beat with nothing owed (%0d,%0d,%0d)",
                                  got.sample_x, got.sample_y, got.sample_z));
      end else begin
        want = expected_samples.pop_front();
        if (got.sample_x !== want.sample_x)
          report_mismatch($sformatf("sample_x got %0d want %0d", got.sample_x, want.sample_x));
        if (got.sample_y !== want.sample_y)
          report_mismatch($sformatf("sample_y got %0d want %0d", got.sample_y, want.sample_y));
        if (got.sample_z !== want.sample_z)
          report_mismatch($sformatf("sample_z got %0d want %0d", got.sample_z, want.sample_z));
        if (got.last_sample !== want.last_sample)
          report_mismatch($sformatf("last_sample got %0b want %0b",
                                    got.last_sample, want.last_sample));
      end
    end
    in_beat = rst_ni && in_valid_i && in_ready_o;
    if (in_beat) predict_samples(in_data_i);
  end

  // --------------------------------------------------------------------------
  // driver: holds a beat until it is taken, then idles for a random gap or
  // offers the next pending point straight away, valid staying high
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_beat) begin
        // beat still waiting for ready, payload held
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_points.size() != 0) begin
        in_data_i  <= pending_points.pop_front();
        in_valid_i <= 1'b1;
        gap_left = (quiet || $urandom_range(0, 99) < 55) ? 0 : next_gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off counted here on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_left = HoldOffCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        stall_left = next_gap_len() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on the whole run, counted in clock cycles
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_basis(input basis_reg_e idx, input cfg_data_t value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    basis_rows[idx] = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_basis(input cfg_data_t t3, input cfg_data_t t2,
                           input cfg_data_t t1, input cfg_data_t t0);
    write_basis(RegRowT3, t3);
    write_basis(RegRowT2, t2);
    write_basis(RegRowT1, t1);
    write_basis(RegRowT0, t0);
  endtask

  task automatic push_point(input coord_t x, input coord_t y, input coord_t z);
    point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    pending_points.push_back(p);
  endtask

  // block idle: nothing left to send, nothing owed, then room for the pipeline
  task automatic wait_idle();
    while (pending_points.size() != 0 || in_valid_i || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // stimulus: reset basis, Bezier with field extremes, saturating basis,
  // then random phases over several basis settings
  // --------------------------------------------------------------------------
  initial begin
    int ph;
    int n;
    for (int r = 0; r < 4; r++) basis_rows[r] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // basis still at reset: history fills, then all-zero samples
    push_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_point(16'sh8000, 16'sh8000, 16'sh8000);
    push_point(16'sd1, -16'sd1, 16'sd0);
    push_point(16'sh7fff, 16'sh8000, 16'sd5);
    push_point(-16'sd300, 16'sd300, 16'sh7fff);
    wait_idle();

    // Bezier: stays inside the hull, exercises negative truncation
    set_basis(pack_row(-4096, 12288, -12288, 4096),
              pack_row(12288, -24576, 12288, 0),
              pack_row(-12288, 12288, 0, 0),
              pack_row(4096, 0, 0, 0));
    push_point(16'sd0, 16'sd0, 16'sd0);
    push_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_point(16'sh8000, 16'sh8000, 16'sh8000);
    push_point(16'sh7fff, 16'sh8000, 16'sd0);
    push_point(16'sh8000, 16'sh7fff, 16'sd1);
    push_point(16'sd1, -16'sd1, -16'sd1);
    push_point(-16'sd1, 16'sd1, 16'sd2);
    push_point(16'sd100, -16'sd3, 16'sd7);
    push_point(-16'sd5, -16'sd7, -16'sd9);
    push_point(16'sh7fff, 16'sd0, 16'sh8000);
    push_point(16'sd0, -16'sd1, 16'sh7fff);
    push_point(16'sh8000, 16'sh8000, 16'sh7fff);
    wait_idle();

    // extreme rows: saturation toward both ends
    set_basis(MaxRow, '0, '0, MinRow);
    push_point(16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_point(16'sh8000, 16'sh8000, 16'sh8000);
    push_point(16'sh7fff, 16'sh8000, 16'sd0);
    push_point(16'sd1, 16'sd1, 16'sd1);
    push_point(-16'sd1, -16'sd1, -16'sd1);
    push_point(16'sd0, 16'sd0, 16'sd0);
    push_point(16'sh8000, 16'sh7fff, 16'sd1);
    push_point(16'sh7fff, 16'sh7fff, 16'sh8000);
    wait_idle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_basis(pack_row(-683, 2048, -2048, 683),       // uniform B-spline
                     pack_row(2048, -4096, 2048, 0),
                     pack_row(-2048, 0, 2048, 0),
                     pack_row(683, 2731, 683, 0));
        1: set_basis(small_row(), small_row(), small_row(), small_row());
        2: set_basis({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        3: set_basis(pack_row(-2048, 6144, -6144, 2048),     // Catmull-Rom
                     pack_row(4096, -10240, 8192, -2048),
                     pack_row(-2048, 0, 2048, 0),
                     pack_row(0, 4096, 0, 0));
        default: set_basis(MinRow, MaxRow, MinRow, MaxRow);
      endcase
      quiet = (ph == 3);
      for (n = 0; n < PhaseItems; n++) begin
        pending_points.push_back(random_point());
        // sender pauses mid-phase until every owed sample is out
        if (ph == 1 && n == PhaseItems / 2) wait_idle();
      end
      // receiver holds off while the sender keeps offering, input must stall
      if (ph == 2) hold_req = 1'b1;
      wait_idle();
    end
    quiet = 1'b0;

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ cubic_curve_subdivider.f @@
hdl/ccs_pkg.sv
hdl/ccs_front.sv
hdl/ccs_fifo.sv
hdl/ccs_coef.sv
hdl/ccs_eval.sv
hdl/cubic_curve_subdivider.sv
hdl/ccs_checker.sv
tb/testbench.sv
